// ----- rtl/median_filter_3x3_rgba_assert.svh -----
// assertion macros shared by the median filter rtl
`ifndef MEDIAN_FILTER_3X3_RGBA_ASSERT_SVH
`define MEDIAN_FILTER_3X3_RGBA_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define MF3_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence must hold in the cycle after the trigger
`define MF3_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mf3_pkg.sv -----
// types, constants and compare helpers of the 3x3 rgba median filter
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;
    localparam int ROW_W          = HEIGHT_FIELD_W;
    localparam int IN_ROW_W       = ROW_W + 1;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = HEIGHT_FIELD_W;
    localparam int CHAN_W         = 8;
    localparam int COLORS         = 3;
    localparam int WIN_TAPS       = 9;
    localparam int WIN_CENTER     = 4;

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t alpha;
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    // index row*3 + column, column 2 newest
    typedef pixel_t [WIN_TAPS-1:0] window_t;

    typedef logic [CHAN_W*COLORS-1:0] color_t;

    typedef struct packed {
        chan_t hi;
        chan_t mid;
        chan_t lo;
    } trio_t;

    function automatic chan_t min8(input chan_t a, input chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic chan_t max8(input chan_t a, input chan_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
        return max8(min8(a, b), min8(max8(a, b), c));
    endfunction

    function automatic trio_t sort3(input chan_t a, input chan_t b, input chan_t c);
        trio_t t;
        t.lo  = min8(min8(a, b), c);
        t.hi  = max8(max8(a, b), c);
        t.mid = med3(a, b, c);
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mf3_median.sv -----
// two-level median network for red, green and blue of a 3x3 window
`default_nettype none

module mf3_median
    import mf3_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  window_t window,
    output color_t  med
);

    for (genvar ch = 0; ch < COLORS; ch++) begin : g_chan
        trio_t rows_reg [3];

        // level one: sort each window row
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    rows_reg[r] <= sort3(window[3*r][CHAN_W*ch +: CHAN_W],
                                         window[3*r+1][CHAN_W*ch +: CHAN_W],
                                         window[3*r+2][CHAN_W*ch +: CHAN_W]);
                end
            end
        end

        // level two: max of lows, median of mids, min of highs, then their median
        assign med[CHAN_W*ch +: CHAN_W] =
            med3(max8(max8(rows_reg[0].lo, rows_reg[1].lo), rows_reg[2].lo),
                 med3(rows_reg[0].mid, rows_reg[1].mid, rows_reg[2].mid),
                 min8(min8(rows_reg[0].hi, rows_reg[1].hi), rows_reg[2].hi));
    end

endmodule

`default_nettype wire

// ----- rtl/median_filter_3x3_rgba.sv -----
// top level of the streaming 3x3 rgba median filter
`default_nettype none

// Streaming 3x3 median filter for RGBA pixels in raster order. The block takes one
// transaction per clock unless out_ready stalls: every input stage, the line stores
// and the median network move together, so throughput is one pixel per cycle and is
// set by the single read and single write each line store does per pixel. A result
// passes the stage-one, stage-two and output registers, and results trail the input
// by one row plus one pixel, so a frame ends with drain transactions (operation = 1)
// that flush the last row. Interior pixels get the per-channel median of red, green
// and blue; alpha and all border pixels pass unchanged, as does every pixel of a
// frame narrower or shorter than three. frame_end marks the last pixel of a frame,
// after which the next frame starts. Width is clamped to 1..1024 and height to at
// least 1; a configuration write restarts the frame, and the user must make it only
// while the block is idle, which it does not enforce. The line stores need no clearing
// pass after reset: no result depends on an entry not written in the current frame.

module median_filter_3x3_rgba
    import mf3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [CHAN_W-1:0]     in_red,
    input  logic [CHAN_W-1:0]     in_green,
    input  logic [CHAN_W-1:0]     in_blue,
    input  logic [CHAN_W-1:0]     in_alpha,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAN_W-1:0]     out_red,
    output logic [CHAN_W-1:0]     out_green,
    output logic [CHAN_W-1:0]     out_blue,
    output logic [CHAN_W-1:0]     out_alpha,
    output logic                  frame_end
);

    // geometry, held as last index
    logic [COL_W-1:0]    w_m1_reg, w_m1_next;
    logic [ROW_W-1:0]    h_m1_reg, h_m1_next;

    // positions of the next input and the next result
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;

    // line stores: upper holds row n-2, lower row n-1
    pixel_t upper_mem [MAX_WIDTH];
    pixel_t lower_mem [MAX_WIDTH];
    pixel_t upper_rd_reg, lower_rd_reg;
    logic   fwd_reg;
    pixel_t fwd_upper_reg, fwd_lower_reg;

    window_t window_reg, window_next;

    // result pipeline
    logic   s1_valid_reg, s1_interior_reg, s1_last_reg;
    pixel_t s1_pix_reg;
    logic   s2_valid_reg, s2_interior_reg, s2_last_reg;
    pixel_t s2_pix_reg;
    logic   out_valid_reg, out_last_reg;
    pixel_t out_pix_reg;

    logic   en, take, step, frame_in_done, col_wrap, emit, out_last, interior, restart;
    pixel_t nw, up, lo;
    color_t med;
    logic [WIDTH_FIELD_W-1:0]  cfg_w;
    logic [HEIGHT_FIELD_W-1:0] cfg_h;

    // whole pipeline moves when the output register is free or being emptied
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign take     = in_valid && en;

    assign frame_in_done = in_row_reg > IN_ROW_W'(h_m1_reg);
    // drain transaction before the frame is in does nothing
    assign step          = take && !(operation && !frame_in_done);

    // once the frame is in, pixel data is ignored and zeros are pushed
    assign nw = frame_in_done ? '0 : pixel_t'({in_alpha, in_blue, in_green, in_red});

    // same entry written last cycle: take the written value
    assign up = fwd_reg ? fwd_upper_reg : upper_rd_reg;
    assign lo = fwd_reg ? fwd_lower_reg : lower_rd_reg;

    assign col_wrap = in_col_reg == w_m1_reg;
    // results start one row plus one pixel into the frame
    assign emit     = (in_row_reg >= IN_ROW_W'(2)) ||
                      (in_row_reg == IN_ROW_W'(1) && in_col_reg != '0);
    assign out_last = (out_row_reg == h_m1_reg) && (out_col_reg == w_m1_reg);
    assign interior = (out_row_reg != '0) && (out_row_reg < h_m1_reg) &&
                      (out_col_reg != '0) && (out_col_reg < w_m1_reg);
    assign restart  = step && emit && out_last;

    assign cfg_w = cfg_data[WIDTH_FIELD_W-1:0];
    assign cfg_h = cfg_data[HEIGHT_FIELD_W-1:0];

    // config decode and position counters
    always_comb
    begin
        w_m1_next    = w_m1_reg;
        h_m1_next    = h_m1_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_w == '0)
                        w_m1_next = '0;
                    else if (int'(cfg_w) > MAX_WIDTH)
                        w_m1_next = COL_W'(MAX_WIDTH - 1);
                    else
                        w_m1_next = COL_W'(cfg_w - WIDTH_FIELD_W'(1));
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_h == '0)
                        h_m1_next = '0;
                    else
                        h_m1_next = ROW_W'(cfg_h - HEIGHT_FIELD_W'(1));
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (step)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end

            if (emit)
            begin
                if (out_col_reg == w_m1_reg)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // window shifts left, new column is upper, lower and incoming pixel
    always_comb
    begin
        window_next = window_reg;
        if (step)
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_next[3*r]   = window_reg[3*r+1];
                window_next[3*r+1] = window_reg[3*r+2];
            end
            window_next[2] = up;
            window_next[5] = lo;
            window_next[8] = nw;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg      <= COL_W'(IMAGE_WIDTH_RESET - 1);
            h_m1_reg      <= ROW_W'(IMAGE_HEIGHT_RESET - 1);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            fwd_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_m1_reg    <= w_m1_next;
            h_m1_reg    <= h_m1_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            fwd_reg     <= step && (in_col_next == in_col_reg);
            if (en)
            begin
                s1_valid_reg  <= step && emit;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // line stores: write the current column, prefetch the next one
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            upper_mem[in_col_reg] <= lo;
            lower_mem[in_col_reg] <= nw;
        end
        upper_rd_reg  <= upper_mem[in_col_next];
        lower_rd_reg  <= lower_mem[in_col_next];
        fwd_upper_reg <= lo;
        fwd_lower_reg <= nw;
    end

    // payload path
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        if (en)
        begin
            // center tap after the shift is the pixel being emitted
            s1_pix_reg      <= window_reg[WIN_CENTER+1];
            s1_interior_reg <= interior;
            s1_last_reg     <= out_last;
            s2_pix_reg      <= s1_pix_reg;
            s2_interior_reg <= s1_interior_reg;
            s2_last_reg     <= s1_last_reg;
            out_pix_reg     <= s2_interior_reg ? pixel_t'({s2_pix_reg.alpha, med})
                                               : s2_pix_reg;
            out_last_reg    <= s2_last_reg;
        end
    end

    // window_reg still holds the stage-one item when the network samples it
    mf3_median u_median (
        .clk    (clk),
        .en     (en),
        .window (window_reg),
        .med    (med)
    );

    assign out_valid = out_valid_reg;
    assign out_red   = out_pix_reg.red;
    assign out_green = out_pix_reg.green;
    assign out_blue  = out_pix_reg.blue;
    assign out_alpha = out_pix_reg.alpha;
    assign frame_end = out_last_reg;

`include "median_filter_3x3_rgba_assert.svh"

    `MF3_ALWAYS(a_in_col_range, in_col_reg <= w_m1_reg, "input column beyond row width")
    `MF3_ALWAYS(a_out_pos_range, out_col_reg <= w_m1_reg && out_row_reg <= h_m1_reg, "result position outside frame")
    `MF3_ALWAYS(a_in_row_range, in_row_reg <= (IN_ROW_W'(h_m1_reg) + IN_ROW_W'(2)), "input row ran past frame drain")
    `MF3_NEXT(a_frame_restart, restart, in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 && out_row_reg == '0, "frame end did not restart positions")

endmodule

`default_nettype wire
